// ----- src/nntt_pkg.sv -----
// nntt_pkg: shared types, codes and modular add/subtract helpers
// for the negacyclic ntt engine. Used by every module of the block but nntt_ram.
package nntt_pkg;

    localparam int P_WORD = 64;
    localparam int CFG_IDX_W = 3;

    typedef logic [P_WORD-1:0] t_word;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODULUS  = 3'd0,
        CFG_ROOT     = 3'd1,
        CFG_ROOT_INV = 3'd2,
        CFG_LEN_INV  = 3'd3,
        CFG_LOG_LEN  = 3'd4,
        CFG_INV_MODE = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2
    } t_opcode;

    typedef enum logic [1:0] {
        A_ONE   = 2'd0,
        A_X     = 2'd1,
        A_HI    = 2'd2,
        A_RDATA = 2'd3
    } t_mul_a;

    typedef enum logic [2:0] {
        B_ROOT    = 3'd0,
        B_LEN_INV = 3'd1,
        B_BASE    = 3'd2,
        B_W       = 3'd3,
        B_RDATA   = 3'd4,
        B_NINV    = 3'd5
    } t_mul_b;

    typedef enum logic [1:0] {
        WR_IN  = 2'd0,
        WR_LO  = 2'd1,
        WR_HI  = 2'd2,
        WR_MUL = 2'd3
    } t_wr_sel;

    typedef struct packed {
        logic    coeff_we;
        t_wr_sel coeff_wsel;
        logic    tw_we;
        logic    mul_start;
        t_mul_a  mul_a;
        t_mul_b  mul_b;
        logic    w_ld;
        logic    lo_ld;
        logic    bfly_fwd;
        logic    bfly_inv;
        logic    x_one;
        logic    x_ld;
        logic    base_ld;
        logic    ninv_ld;
        logic    out_ld;
    } t_dp_cmd;

    // a, b below q
    function automatic t_word add_mod(input t_word a, input t_word b, input t_word q);
        t_word room;
        room = q - b;
        return (a >= room) ? (a - room) : (a + b);
    endfunction

    function automatic t_word sub_mod(input t_word a, input t_word b, input t_word q);
        return (a >= b) ? (a - b) : (a + (q - b));
    endfunction

endpackage

// ----- src/nntt_ram.sv -----
// nntt_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module nntt_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- src/nntt_mulmod.sv -----
// nntt_mulmod: bit-serial modular multiplier, one bit of b per cycle (msb first).
// Depends on nntt_pkg for the modular add helper. Operand a must be below q.
module nntt_mulmod #(
    parameter int WIDTH = 62
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_a,
    input  logic [WIDTH-1:0] i_b,
    input  logic [WIDTH-1:0] i_q,
    output logic             o_done,
    output logic [WIDTH-1:0] o_result
);
    import nntt_pkg::*;

    localparam int CW = $clog2(WIDTH);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_a;
    logic [WIDTH-1:0] r_b;
    logic [WIDTH-1:0] r_acc;
    t_word            dbl;
    t_word            n_acc;

    function automatic t_word ext(input logic [WIDTH-1:0] v);
        return {{(P_WORD-WIDTH){1'b0}}, v};
    endfunction

    always_comb begin
        dbl   = add_mod(ext(r_acc), ext(r_acc), ext(i_q));
        n_acc = r_b[WIDTH-1] ? add_mod(dbl, ext(r_a), ext(i_q)) : dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= n_acc[WIDTH-1:0];
            r_b   <= r_b << 1;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

// ----- src/nntt_datapath.sv -----
// nntt_datapath: coefficient and twiddle memories, modular multiplier,
// butterfly registers and output data register. Depends on nntt_pkg, nntt_ram, nntt_mulmod.
module nntt_datapath #(
    parameter int WIDTH  = 62,
    parameter int LOG_MAX = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  nntt_pkg::t_dp_cmd        i_cmd,
    input  logic [LOG_MAX-1:0]       i_coeff_raddr,
    input  logic [LOG_MAX-1:0]       i_coeff_waddr,
    input  logic [LOG_MAX-1:0]       i_tw_raddr,
    input  logic [LOG_MAX-1:0]       i_tw_waddr,
    input  logic [WIDTH-1:0]         i_coeff_in,
    input  logic [WIDTH-1:0]         i_q,
    input  logic [WIDTH-1:0]         i_root,
    input  logic [WIDTH-1:0]         i_root_inv,
    input  logic [WIDTH-1:0]         i_len_inv,
    input  logic                     i_inv_mode,
    output logic                     o_mul_done,
    output logic [WIDTH-1:0]         o_coeff_out
);
    import nntt_pkg::*;

    localparam int DEPTH = 1 << LOG_MAX;

    logic [WIDTH-1:0] r_lo, r_hi, r_w, r_x, r_base, r_ninv, r_out;
    logic [WIDTH-1:0] coeff_rdata, tw_rdata, coeff_wdata;
    logic [WIDTH-1:0] mul_a, mul_b, mul_res;
    t_word            sum_fwd, dif_fwd, sum_inv, dif_inv;

    function automatic t_word ext(input logic [WIDTH-1:0] v);
        return {{(P_WORD-WIDTH){1'b0}}, v};
    endfunction

    nntt_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_coeff_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.coeff_we),
        .i_waddr (i_coeff_waddr),
        .i_wdata (coeff_wdata),
        .i_raddr (i_coeff_raddr),
        .o_rdata (coeff_rdata)
    );

    nntt_ram #(.WIDTH(WIDTH), .DEPTH(DEPTH)) u_tw_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tw_we),
        .i_waddr (i_tw_waddr),
        .i_wdata (r_x),
        .i_raddr (i_tw_raddr),
        .o_rdata (tw_rdata)
    );

    nntt_mulmod #(.WIDTH(WIDTH)) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.mul_start),
        .i_a      (mul_a),
        .i_b      (mul_b),
        .i_q      (i_q),
        .o_done   (o_mul_done),
        .o_result (mul_res)
    );

    always_comb begin
        case (i_cmd.mul_a)
            A_ONE:   mul_a = WIDTH'(1);
            A_X:     mul_a = r_x;
            A_HI:    mul_a = r_hi;
            A_RDATA: mul_a = coeff_rdata;
            default: mul_a = WIDTH'(1);
        endcase
        case (i_cmd.mul_b)
            B_ROOT:    mul_b = i_inv_mode ? i_root_inv : i_root;
            B_LEN_INV: mul_b = i_len_inv;
            B_BASE:    mul_b = r_base;
            B_W:       mul_b = r_w;
            B_RDATA:   mul_b = coeff_rdata;
            B_NINV:    mul_b = r_ninv;
            default:   mul_b = '0;
        endcase
        case (i_cmd.coeff_wsel)
            WR_IN:   coeff_wdata = i_coeff_in;
            WR_LO:   coeff_wdata = r_lo;
            WR_HI:   coeff_wdata = r_hi;
            WR_MUL:  coeff_wdata = mul_res;
            default: coeff_wdata = i_coeff_in;
        endcase
        sum_fwd = add_mod(ext(r_lo), ext(mul_res), ext(i_q));
        dif_fwd = sub_mod(ext(r_lo), ext(mul_res), ext(i_q));
        sum_inv = add_mod(ext(r_lo), ext(coeff_rdata), ext(i_q));
        dif_inv = sub_mod(ext(r_lo), ext(coeff_rdata), ext(i_q));
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.w_ld) begin
            r_w <= tw_rdata;
        end
        if (i_cmd.lo_ld) begin
            r_lo <= coeff_rdata;
        end else if (i_cmd.bfly_fwd) begin
            r_lo <= sum_fwd[WIDTH-1:0];
        end else if (i_cmd.bfly_inv) begin
            r_lo <= sum_inv[WIDTH-1:0];
        end
        if (i_cmd.bfly_fwd) begin
            r_hi <= dif_fwd[WIDTH-1:0];
        end else if (i_cmd.bfly_inv) begin
            r_hi <= dif_inv[WIDTH-1:0];
        end
        if (i_cmd.x_one) begin
            r_x <= WIDTH'(1);
        end else if (i_cmd.x_ld) begin
            r_x <= mul_res;
        end
        if (i_cmd.base_ld) begin
            r_base <= mul_res;
        end
        if (i_cmd.ninv_ld) begin
            r_ninv <= mul_res;
        end
        if (i_cmd.out_ld) begin
            r_out <= coeff_rdata;
        end
    end

    assign o_coeff_out = r_out;

endmodule

// ----- src/nntt_ctrl.sv -----
// nntt_ctrl: sequencer for load, read and transform requests; drives the datapath
// through t_dp_cmd and memory addresses. Depends on nntt_pkg.
module nntt_ctrl #(
    parameter int LOG_MAX = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_opcode,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic                  o_out_last,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_clear,
    input  logic [3:0]            i_log_len,
    input  logic                  i_inv_mode,
    input  logic                  i_bypass,
    input  logic                  i_mul_done,
    output nntt_pkg::t_dp_cmd     o_cmd,
    output logic [LOG_MAX-1:0]    o_coeff_raddr,
    output logic [LOG_MAX-1:0]    o_coeff_waddr,
    output logic [LOG_MAX-1:0]    o_tw_raddr,
    output logic [LOG_MAX-1:0]    o_tw_waddr
);
    import nntt_pkg::*;

    localparam int A  = LOG_MAX;
    localparam int LW = $clog2(LOG_MAX + 1);
    localparam logic [LW-1:0] A_L = LW'(LOG_MAX);
    localparam logic [A-1:0]  ALL1 = {A{1'b1}};

    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_NINV_GO   = 18'h00002,
        S_NINV_WAIT = 18'h00004,
        S_BASE_GO   = 18'h00008,
        S_BASE_WAIT = 18'h00010,
        S_TW_WR     = 18'h00020,
        S_TW_WAIT   = 18'h00040,
        S_RED_RD    = 18'h00080,
        S_RED_CAP   = 18'h00100,
        S_RED_WAIT  = 18'h00200,
        S_BF_TW     = 18'h00400,
        S_BF_LO     = 18'h00800,
        S_BF_HI     = 18'h01000,
        S_BF_CAP    = 18'h02000,
        S_BF_MGO    = 18'h04000,
        S_BF_WAIT   = 18'h08000,
        S_BF_WR0    = 18'h10000,
        S_BF_WR1    = 18'h20000
    } t_state;

    t_state         r_state, n_state;
    logic [A-1:0]   r_load_ptr, n_load_ptr;
    logic [A-1:0]   r_read_ptr, n_read_ptr;
    logic [A-1:0]   r_idx, n_idx;
    logic [A-1:0]   r_j, n_j;
    logic [LW-1:0]  r_lt, n_lt;
    logic           r_scale, n_scale;
    logic           r_tv, n_tv;
    logic           r_rd_pend, n_rd_pend;
    logic           r_last_pend, n_last_pend;
    logic           r_out_valid, n_out_valid;
    logic           r_out_last, n_out_last;

    logic [LW-1:0]  lg;
    logic [A-1:0]   nmask, half, tmask, tbit, k, kt, m, rev, lp, rp;
    logic           accept;

    // effective transform size and butterfly addressing
    always_comb begin
        if (i_log_len == 4'd0) begin
            lg = LW'(1);
        end else if (int'(i_log_len) > LOG_MAX) begin
            lg = A_L;
        end else begin
            lg = LW'(i_log_len);
        end
        nmask = ALL1 >> (A_L - lg);
        half  = nmask >> 1;
        tmask = ~(ALL1 << r_lt);
        tbit  = A'(1) << r_lt;
        k     = ((r_j & ~tmask) << 1) | (r_j & tmask);
        kt    = k | tbit;
        m     = A'(1) << (lg - LW'(1) - r_lt);
        for (int b = 0; b < A; b++) begin
            rev[b] = r_idx[A-1-b];
        end
        lp = r_load_ptr & nmask;
        rp = r_read_ptr & nmask;
    end

    assign o_in_ready  = (r_state == S_IDLE) && !r_rd_pend &&
                         ((i_opcode != OP_READ) || !r_out_valid || i_out_ready);
    assign o_cfg_ready = (r_state == S_IDLE) && !r_rd_pend;
    assign accept      = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_load_ptr  = r_load_ptr;
        n_read_ptr  = r_read_ptr;
        n_idx       = r_idx;
        n_j         = r_j;
        n_lt        = r_lt;
        n_scale     = r_scale;
        n_tv        = r_tv;
        n_rd_pend   = r_rd_pend;
        n_last_pend = r_last_pend;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        o_cmd         = '0;
        o_coeff_raddr = rp;
        o_coeff_waddr = lp;
        o_tw_raddr    = m | (r_j >> r_lt);
        o_tw_waddr    = rev >> (A_L - lg);

        // registered read data is loaded into the output register in the cycle after the request
        if (r_rd_pend) begin
            o_cmd.out_ld = 1'b1;
            n_out_valid  = 1'b1;
            n_out_last   = r_last_pend;
            n_rd_pend    = 1'b0;
        end else if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                o_cmd.coeff_wsel = WR_IN;
                if (accept) begin
                    case (i_opcode)
                        OP_LOAD: begin
                            o_cmd.coeff_we = 1'b1;
                            n_load_ptr     = (lp + 1'b1) & nmask;
                        end
                        OP_READ: begin
                            n_rd_pend   = 1'b1;
                            n_last_pend = (rp == nmask);
                            n_read_ptr  = (rp + 1'b1) & nmask;
                        end
                        OP_RUN: begin
                            n_load_ptr = '0;
                            n_read_ptr = '0;
                            if (!i_bypass) begin
                                n_state = S_NINV_GO;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_NINV_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_a     = A_ONE;
                o_cmd.mul_b     = B_LEN_INV;
                n_state         = S_NINV_WAIT;
            end
            S_NINV_WAIT: begin
                n_idx   = '0;
                n_scale = 1'b0;
                if (i_mul_done) begin
                    o_cmd.ninv_ld = 1'b1;
                    n_state       = r_tv ? S_RED_RD : S_BASE_GO;
                end
            end
            S_BASE_GO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_a     = A_ONE;
                o_cmd.mul_b     = B_ROOT;
                o_cmd.x_one     = 1'b1;
                n_state         = S_BASE_WAIT;
            end
            S_BASE_WAIT: begin
                if (i_mul_done) begin
                    o_cmd.base_ld = 1'b1;
                    n_idx         = '0;
                    n_state       = S_TW_WR;
                end
            end
            S_TW_WR: begin
                // twiddle goes to its bit-reversed slot, next power starts at once
                o_cmd.tw_we     = 1'b1;
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_a     = A_X;
                o_cmd.mul_b     = B_BASE;
                n_state         = S_TW_WAIT;
            end
            S_TW_WAIT: begin
                if (i_mul_done) begin
                    o_cmd.x_ld = 1'b1;
                    if (r_idx == nmask) begin
                        n_idx   = '0;
                        n_tv    = 1'b1;
                        n_state = S_RED_RD;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_TW_WR;
                    end
                end
            end
            S_RED_RD: begin
                o_coeff_raddr = r_idx;
                n_state       = S_RED_CAP;
            end
            S_RED_CAP: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_a     = r_scale ? A_RDATA : A_ONE;
                o_cmd.mul_b     = r_scale ? B_NINV : B_RDATA;
                n_state         = S_RED_WAIT;
            end
            S_RED_WAIT: begin
                o_coeff_waddr    = r_idx;
                o_cmd.coeff_wsel = WR_MUL;
                if (i_mul_done) begin
                    o_cmd.coeff_we = 1'b1;
                    if (r_idx == nmask) begin
                        n_idx = '0;
                        if (r_scale) begin
                            n_state = S_IDLE;
                        end else begin
                            n_j     = '0;
                            n_lt    = i_inv_mode ? '0 : (lg - LW'(1));
                            n_state = S_BF_TW;
                        end
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_RED_RD;
                    end
                end
            end
            S_BF_TW: begin
                n_state = S_BF_LO;
            end
            S_BF_LO: begin
                o_cmd.w_ld    = 1'b1;
                o_coeff_raddr = k;
                n_state       = S_BF_HI;
            end
            S_BF_HI: begin
                o_cmd.lo_ld   = 1'b1;
                o_coeff_raddr = kt;
                n_state       = S_BF_CAP;
            end
            S_BF_CAP: begin
                if (i_inv_mode) begin
                    o_cmd.bfly_inv = 1'b1;
                    n_state        = S_BF_MGO;
                end else begin
                    o_cmd.mul_start = 1'b1;
                    o_cmd.mul_a     = A_RDATA;
                    o_cmd.mul_b     = B_W;
                    n_state         = S_BF_WAIT;
                end
            end
            S_BF_MGO: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_a     = A_HI;
                o_cmd.mul_b     = B_W;
                n_state         = S_BF_WAIT;
            end
            S_BF_WAIT: begin
                if (i_mul_done) begin
                    o_cmd.bfly_fwd = !i_inv_mode;
                    n_state        = S_BF_WR0;
                end
            end
            S_BF_WR0: begin
                o_cmd.coeff_we   = 1'b1;
                o_cmd.coeff_wsel = WR_LO;
                o_coeff_waddr    = k;
                n_state          = S_BF_WR1;
            end
            S_BF_WR1: begin
                o_cmd.coeff_we   = 1'b1;
                o_cmd.coeff_wsel = i_inv_mode ? WR_MUL : WR_HI;
                o_coeff_waddr    = kt;
                n_state          = S_BF_TW;
                if (r_j == half) begin
                    n_j = '0;
                    if (!i_inv_mode) begin
                        if (r_lt == '0) begin
                            n_state = S_IDLE;
                        end else begin
                            n_lt = r_lt - 1'b1;
                        end
                    end else if (r_lt == (lg - LW'(1))) begin
                        // inverse ends with the scaling pass
                        n_idx   = '0;
                        n_scale = 1'b1;
                        n_state = S_RED_RD;
                    end else begin
                        n_lt = r_lt + 1'b1;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_clear) begin
            n_tv = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_load_ptr  <= '0;
            r_read_ptr  <= '0;
            r_idx       <= '0;
            r_j         <= '0;
            r_lt        <= '0;
            r_scale     <= 1'b0;
            r_tv        <= 1'b0;
            r_rd_pend   <= 1'b0;
            r_last_pend <= 1'b0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_ptr  <= n_load_ptr;
            r_read_ptr  <= n_read_ptr;
            r_idx       <= n_idx;
            r_j         <= n_j;
            r_lt        <= n_lt;
            r_scale     <= n_scale;
            r_tv        <= n_tv;
            r_rd_pend   <= n_rd_pend;
            r_last_pend <= n_last_pend;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;

endmodule

// ----- src/negacyclic_ntt_engine.sv -----
// Negacyclic NTT engine over n = 2^L coefficients mod a prime q. Loads are written
// straight into the coefficient memory and can follow one another back to back; a
// read request passes through the registered memory read and then the output
// register. A transform request stalls the input while the bit-serial modular
// multiplier works through its steps: it sets up n^-1, after a configuration write
// also the root and the twiddle table, then runs the initial reduction pass, the
// (n/2)*L butterflies and, for the inverse, the scaling pass. A root of 0 or 1
// makes the transform request only reset the load and read pointers.
// Top level; depends on nntt_pkg, nntt_ctrl and nntt_datapath.
module negacyclic_ntt_engine #(
    parameter int MAX_LOG_LENGTH = 12,
    parameter int COEFF_WIDTH    = 62
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_opcode,
    input  logic [COEFF_WIDTH-1:0]            i_coeff_in,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [COEFF_WIDTH-1:0]            o_coeff_out,
    output logic                              o_last_coeff,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [nntt_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [COEFF_WIDTH-1:0]            i_cfg_data
);
    import nntt_pkg::*;

    logic [COEFF_WIDTH-1:0] r_modulus, r_root, r_root_inv, r_len_inv;
    logic [3:0]             r_log_len;
    logic                   r_inv_mode;
    logic [COEFF_WIDTH-1:0] q_eff;
    logic                   bypass, cfg_wr, cfg_hit;
    logic                   mul_done;
    t_dp_cmd                cmd;
    logic [MAX_LOG_LENGTH-1:0] coeff_raddr, coeff_waddr, tw_raddr, tw_waddr;

    assign cfg_wr = i_cfg_valid && o_cfg_ready;
    assign q_eff  = (r_modulus < COEFF_WIDTH'(3)) ? COEFF_WIDTH'(3) : r_modulus;
    assign bypass = (r_root == '0) || (r_root == COEFF_WIDTH'(1));

    always_comb begin
        unique case (i_cfg_index)
            CFG_MODULUS, CFG_ROOT, CFG_ROOT_INV,
            CFG_LEN_INV, CFG_LOG_LEN, CFG_INV_MODE: cfg_hit = cfg_wr;
            default:                                cfg_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= COEFF_WIDTH'(3);
            r_root     <= '0;
            r_root_inv <= '0;
            r_len_inv  <= COEFF_WIDTH'(1);
            r_log_len  <= 4'd12;
            r_inv_mode <= 1'b0;
        end else if (cfg_wr) begin
            unique case (i_cfg_index)
                CFG_MODULUS:  r_modulus  <= i_cfg_data;
                CFG_ROOT:     r_root     <= i_cfg_data;
                CFG_ROOT_INV: r_root_inv <= i_cfg_data;
                CFG_LEN_INV:  r_len_inv  <= i_cfg_data;
                CFG_LOG_LEN:  r_log_len  <= i_cfg_data[3:0];
                CFG_INV_MODE: r_inv_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    nntt_ctrl #(.LOG_MAX(MAX_LOG_LENGTH)) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_opcode      (i_opcode),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_out_last    (o_last_coeff),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_clear   (cfg_hit),
        .i_log_len     (r_log_len),
        .i_inv_mode    (r_inv_mode),
        .i_bypass      (bypass),
        .i_mul_done    (mul_done),
        .o_cmd         (cmd),
        .o_coeff_raddr (coeff_raddr),
        .o_coeff_waddr (coeff_waddr),
        .o_tw_raddr    (tw_raddr),
        .o_tw_waddr    (tw_waddr)
    );

    nntt_datapath #(.WIDTH(COEFF_WIDTH), .LOG_MAX(MAX_LOG_LENGTH)) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_coeff_raddr (coeff_raddr),
        .i_coeff_waddr (coeff_waddr),
        .i_tw_raddr    (tw_raddr),
        .i_tw_waddr    (tw_waddr),
        .i_coeff_in    (i_coeff_in),
        .i_q           (q_eff),
        .i_root        (r_root),
        .i_root_inv    (r_root_inv),
        .i_len_inv     (r_len_inv),
        .i_inv_mode    (r_inv_mode),
        .o_mul_done    (mul_done),
        .o_coeff_out   (o_coeff_out)
    );

endmodule

// ----- src/nntt_checker.sv -----
// nntt_checker: port-level assertions for negacyclic_ntt_engine, attached by bind.
// Depends on nntt_pkg for opcode names.
module nntt_checker #(
    parameter int COEFF_WIDTH = 62
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   o_in_ready,
    input logic [1:0]             i_opcode,
    input logic                   o_out_valid,
    input logic                   i_out_ready,
    input logic [COEFF_WIDTH-1:0] o_coeff_out,
    input logic                   o_last_coeff,
    input logic                   o_cfg_ready
);
    import nntt_pkg::*;

    // a pending result holds its value until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_coeff_out) && $stable(o_last_coeff))
        else $error("result changed while stalled");

    // read request shows a result after the registered read and the output register
    a_read_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_opcode == OP_READ) |=> ##1 o_out_valid)
        else $error("read request produced no result");

    // no result without a read request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && o_in_ready && (i_opcode == OP_READ), 2))
        else $error("result without read request");

    // busy engine takes neither requests nor configuration
    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_cfg_ready |-> !o_in_ready)
        else $error("request taken while busy");

endmodule

bind negacyclic_ntt_engine nntt_checker #(.COEFF_WIDTH(COEFF_WIDTH)) u_nntt_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_opcode     (i_opcode),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_coeff_out  (o_coeff_out),
    .o_last_coeff (o_last_coeff),
    .o_cfg_ready  (o_cfg_ready)
);
